[sv/gradient_noise_3d_eval_defines.svh]
// Assertion macros shared by the gradient noise RTL.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef GRADIENT_NOISE_3D_EVAL_DEFINES_SVH
`define GRADIENT_NOISE_3D_EVAL_DEFINES_SVH

// same-cycle implication, off during reset
`define GN3_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gn3 assertion failed");

// next-cycle implication, off during reset
`define GN3_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gn3 assertion failed");

`endif

[sv/gn3_pkg.sv]
// Shared constants and types for the 3D gradient noise evaluator.
// No dependencies.
`timescale 1ns / 1ps

package gn3_pkg;

    localparam int LATTICE_SIZE   = 256;
    localparam int FRAC_BITS      = 16;
    localparam int GRAD_FRAC_BITS = 14;

    localparam int LAT_BITS   = $clog2(LATTICE_SIZE);
    localparam int PERM_DEPTH = 2 * LATTICE_SIZE;
    localparam int PERM_AW    = $clog2(PERM_DEPTH);
    localparam int PERM_W     = 8;
    localparam int GRAD_W     = 16;
    localparam int GRAD_WORD_W = 3 * GRAD_W;
    localparam int COORD_W    = 24;
    localparam int IDX_W      = 9;
    localparam int OUT_W      = 18;
    localparam int OUT_FRAC   = 16;

    localparam int S_TDATA_W = 144;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    // command codes
    localparam logic [1:0] CMD_LOAD_PERM = 2'd0;
    localparam logic [1:0] CMD_LOAD_GRAD = 2'd1;
    localparam logic [1:0] CMD_EVAL      = 2'd2;

    // dot products and lerp results, signed Q.FRAC_BITS
    localparam int DOT_W = FRAC_BITS + 5;

    typedef logic [FRAC_BITS-1:0]        t_frac;
    typedef logic [FRAC_BITS:0]          t_fade;
    typedef logic [LAT_BITS-1:0]         t_lat;
    typedef logic [PERM_W-1:0]           t_perm;
    typedef logic [PERM_AW-1:0]          t_paddr;
    typedef logic [GRAD_WORD_W-1:0]      t_gword;
    typedef logic signed [DOT_W-1:0]     t_dot;

endpackage

[sv/gradient_noise_3d_eval.sv]
// 3D gradient noise evaluator: one evaluation beat in, one noise value out.
// Throughput one beat per cycle while the output register is empty or being
// taken; the pipeline, r0 through the output register, advances as one.
// Reset (synchronous, i_rst_n low) clears all stage valid bits; the
// permutation and gradient tables keep no reset and must be loaded first.
`timescale 1ns / 1ps
`include "gradient_noise_3d_eval_defines.svh"

module gradient_noise_3d_eval (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata, low bit up: table_index[8:0], perm_value[16:9], grad_x[32:17],
    // grad_y[48:33], grad_z[64:49], coord_x[88:65], coord_y[112:89],
    // coord_z[136:113], zero pad[143:137]
    input  logic [gn3_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [gn3_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata, low bit up: noise_value[17:0], zero pad[23:18]
    output logic [gn3_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    // ------------------------------------------------------------------
    // Pipeline map
    //   r0  : input register; perm copy 1 read/write (x corners)
    //   r1  : perm copies 2a/2b read/write (x,y corners); fade k, t^2
    //   r2  : perm copies 3a..3d read/write (all corners); fade t^3, m
    //   r3  : gradient copies read/write; fade r
    //   r4  : gradient * offset products; fade u
    //   r5  : three-term sums -> dot products
    //   r6..r11 : three lerp levels, multiply then add
    //   out : +1/2, saturate, output register
    // Every table copy is written by a load beat at the same stage that
    // reads it, so reads and writes hit each copy in beat order.
    // ------------------------------------------------------------------

    localparam int FB    = gn3_pkg::FRAC_BITS;
    localparam int GFB   = gn3_pkg::GRAD_FRAC_BITS;
    localparam int GW    = gn3_pkg::GRAD_W;
    localparam int CW    = gn3_pkg::COORD_W;
    localparam int LB    = gn3_pkg::LAT_BITS;
    localparam int PAW   = gn3_pkg::PERM_AW;
    localparam int DW    = gn3_pkg::DOT_W;
    localparam int MW    = gn3_pkg::M_TDATA_W;
    localparam int KW    = FB + 4;                 // 15*ONE - 6t
    localparam int PW    = 2 * GW + 1;             // grad * offset
    localparam int SW    = PW + 2;                 // sum of three
    localparam int LDW   = DW + 1;                 // lerp difference
    localparam int LPW   = LDW + FB + 2;           // lerp product
    localparam int LSW   = LPW - FB + 1;           // lerp sum
    localparam int UPW   = FB + 1 + KW + 1;        // t3 * r

    localparam logic [KW-1:0]           FADE_C15 = KW'(15 * (2 ** FB));
    localparam logic [KW-1:0]           FADE_C10 = KW'(10 * (2 ** FB));
    localparam gn3_pkg::t_fade          ONE_U    = (FB + 1)'(2 ** FB);
    localparam logic signed [UPW-FB-1:0] ONE_S   = (UPW - FB)'(2 ** FB);
    localparam logic signed [LSW-1:0]   HALF     = LSW'(2 ** (FB - 1));
    localparam logic signed [LSW-1:0]   SAT_MAX  = LSW'((2 ** (gn3_pkg::OUT_W - 1)) - 1);
    localparam logic signed [LSW-1:0]   SAT_MIN  = -LSW'(2 ** (gn3_pkg::OUT_W - 1));

    // ---------------- input unpack ----------------
    logic [1:0]                 in_cmd;
    logic [gn3_pkg::IDX_W-1:0]  in_idx;
    gn3_pkg::t_perm             in_pval;
    gn3_pkg::t_gword            in_grad;
    logic [CW-1:0]              in_coord [3];
    logic                       in_known;
    logic                       en;

    assign in_cmd      = s_axis_tuser[1:0];
    assign in_idx      = s_axis_tdata[8:0];
    assign in_pval     = s_axis_tdata[16:9];
    assign in_grad     = s_axis_tdata[64:17];
    assign in_coord[0] = s_axis_tdata[88:65];
    assign in_coord[1] = s_axis_tdata[112:89];
    assign in_coord[2] = s_axis_tdata[136:113];
    // cmd 3 means nothing; it is taken and dropped
    assign in_known = (in_cmd == gn3_pkg::CMD_LOAD_PERM) || (in_cmd == gn3_pkg::CMD_LOAD_GRAD)
                   || (in_cmd == gn3_pkg::CMD_EVAL);

    // whole pipeline moves together; output register decouples the sink
    logic r_out_valid;
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- stage registers ----------------
    logic                      r0_valid, r1_valid, r2_valid, r3_valid;
    logic [1:0]                r0_cmd, r1_cmd, r2_cmd, r3_cmd;
    logic [gn3_pkg::IDX_W-1:0] r0_idx, r1_idx, r2_idx, r3_idx;
    gn3_pkg::t_perm            r0_pval, r1_pval;
    gn3_pkg::t_gword           r0_grad, r1_grad, r2_grad, r3_grad;
    gn3_pkg::t_frac            r0_t [3];
    gn3_pkg::t_frac            r1_t [3];
    gn3_pkg::t_frac            r2_t [3];
    gn3_pkg::t_frac            r3_t [3];
    gn3_pkg::t_frac            r4_t [3];
    gn3_pkg::t_lat             r0_lo [3];
    gn3_pkg::t_lat             r1_lo [3];
    gn3_pkg::t_lat             r2_lo [3];

    logic [KW-1:0]             r1_k  [3];
    gn3_pkg::t_frac            r1_t2 [3];
    gn3_pkg::t_frac            r2_t3 [3];
    logic [KW-1:0]             r2_m  [3];
    gn3_pkg::t_frac            r3_t3 [3];
    logic signed [KW:0]        r3_rr [3];

    logic                      r4_valid, r5_valid, r6_valid, r7_valid;
    logic                      r8_valid, r9_valid, r10_valid, r11_valid;
    gn3_pkg::t_fade            r4_u [3];
    gn3_pkg::t_fade            r5_u [3];
    gn3_pkg::t_fade            r6_u [3];
    gn3_pkg::t_fade            r7_u [3];
    gn3_pkg::t_fade            r8_u [3];
    gn3_pkg::t_fade            r9_u [3];
    logic signed [PW-1:0]      r5_prod [8][3];
    gn3_pkg::t_dot             r6_d [8];
    gn3_pkg::t_dot             r7_a [4];
    logic signed [LPW-1:0]     r7_p [4];
    gn3_pkg::t_dot             r8_l [4];
    gn3_pkg::t_dot             r9_a [2];
    logic signed [LPW-1:0]     r9_p [2];
    gn3_pkg::t_dot             r10_l [2];
    gn3_pkg::t_fade            r10_u2;
    gn3_pkg::t_dot             r11_a;
    logic signed [LPW-1:0]     r11_p;
    logic [gn3_pkg::OUT_W-1:0] r_out_data;

    // perm word carried into stage 2 for the third copy
    gn3_pkg::t_perm            r1_pval_d;

    // ---------------- table copies ----------------
    gn3_pkg::t_perm  w_p1 [2];
    gn3_pkg::t_perm  w_p2 [4];
    gn3_pkg::t_perm  w_p3 [8];
    gn3_pkg::t_gword w_g  [8];
    gn3_pkg::t_paddr addr1 [2];
    gn3_pkg::t_paddr addr2 [4];
    gn3_pkg::t_paddr addr3 [8];
    gn3_pkg::t_lat   gaddr [8];
    logic            we1, we2, we3, weg;

    assign we1 = en && r0_valid && (r0_cmd == gn3_pkg::CMD_LOAD_PERM);
    assign we2 = en && r1_valid && (r1_cmd == gn3_pkg::CMD_LOAD_PERM);
    assign we3 = en && r2_valid && (r2_cmd == gn3_pkg::CMD_LOAD_PERM);
    assign weg = en && r3_valid && (r3_cmd == gn3_pkg::CMD_LOAD_GRAD);

    // hash addresses: x corners, then +y, then +z; sums stay below 2*lattice
    always_comb begin
        gn3_pkg::t_lat yy [2];
        gn3_pkg::t_lat zz [2];
        yy[0] = r1_lo[1];
        yy[1] = LB'(r1_lo[1] + 1'b1);
        zz[0] = r2_lo[2];
        zz[1] = LB'(r2_lo[2] + 1'b1);
        addr1[0] = PAW'(r0_lo[0]);
        addr1[1] = PAW'(LB'(r0_lo[0] + 1'b1));
        for (int j = 0; j < 4; j++) begin
            addr2[j] = PAW'(w_p1[j % 2]) + PAW'(yy[j / 2]);
        end
        for (int i = 0; i < 8; i++) begin
            addr3[i] = PAW'(w_p2[i % 4]) + PAW'(zz[i / 4]);
            gaddr[i] = w_p3[i][LB-1:0];
        end
    end

    gn3_ram #(.WIDTH(gn3_pkg::PERM_W), .DEPTH(gn3_pkg::PERM_DEPTH)) u_perm1 (
        .i_clk(i_clk), .i_en(en), .i_we(we1), .i_waddr(r0_idx), .i_wdata(r0_pval),
        .i_raddr_a(addr1[0]), .i_raddr_b(addr1[1]),
        .o_rdata_a(w_p1[0]), .o_rdata_b(w_p1[1])
    );

    for (genvar c = 0; c < 2; c++) begin : g_perm2
        gn3_ram #(.WIDTH(gn3_pkg::PERM_W), .DEPTH(gn3_pkg::PERM_DEPTH)) u_perm2 (
            .i_clk(i_clk), .i_en(en), .i_we(we2), .i_waddr(r1_idx), .i_wdata(r1_pval),
            .i_raddr_a(addr2[2*c]), .i_raddr_b(addr2[2*c+1]),
            .o_rdata_a(w_p2[2*c]), .o_rdata_b(w_p2[2*c+1])
        );
    end

    for (genvar c = 0; c < 4; c++) begin : g_perm3
        gn3_ram #(.WIDTH(gn3_pkg::PERM_W), .DEPTH(gn3_pkg::PERM_DEPTH)) u_perm3 (
            .i_clk(i_clk), .i_en(en), .i_we(we3), .i_waddr(r2_idx), .i_wdata(r1_pval_d),
            .i_raddr_a(addr3[2*c]), .i_raddr_b(addr3[2*c+1]),
            .o_rdata_a(w_p3[2*c]), .o_rdata_b(w_p3[2*c+1])
        );
    end

    for (genvar c = 0; c < 4; c++) begin : g_grad
        gn3_ram #(.WIDTH(gn3_pkg::GRAD_WORD_W), .DEPTH(gn3_pkg::LATTICE_SIZE)) u_grad (
            .i_clk(i_clk), .i_en(en), .i_we(weg), .i_waddr(r3_idx[LB-1:0]),
            .i_wdata(r3_grad),
            .i_raddr_a(gaddr[2*c]), .i_raddr_b(gaddr[2*c+1]),
            .o_rdata_a(w_g[2*c]), .o_rdata_b(w_g[2*c+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pval_d <= r1_pval;
        end
    end

    // ---------------- fade: 6t^5 - 15t^4 + 10t^3 ----------------
    logic [KW-1:0]           n1_k  [3];
    gn3_pkg::t_frac          n1_t2 [3];
    gn3_pkg::t_frac          n2_t3 [3];
    logic [KW-1:0]           n2_m  [3];
    logic signed [KW:0]      n3_rr [3];
    gn3_pkg::t_fade          n4_u  [3];

    always_comb begin
        logic [2*FB-1:0]        sq;
        logic [2*FB-1:0]        cu;
        logic [FB+KW-1:0]       tk;
        logic signed [UPW-1:0]  up;
        logic signed [UPW-FB-1:0] uf;
        for (int a = 0; a < 3; a++) begin
            sq = (2*FB)'(r0_t[a]) * (2*FB)'(r0_t[a]);
            n1_t2[a] = sq[2*FB-1:FB];
            n1_k[a]  = FADE_C15 - KW'({r0_t[a], 2'b00}) - KW'({r0_t[a], 1'b0});
            cu = (2*FB)'(r1_t2[a]) * (2*FB)'(r1_t[a]);
            n2_t3[a] = cu[2*FB-1:FB];
            tk = (FB+KW)'(r1_t[a]) * (FB+KW)'(r1_k[a]);
            n2_m[a]  = tk[FB+KW-1:FB];
            n3_rr[a] = $signed({1'b0, FADE_C10}) - $signed({1'b0, r2_m[a]});
            up = $signed({1'b0, r3_t3[a]}) * r3_rr[a];
            uf = up[UPW-1:FB];
            n4_u[a] = (uf > ONE_S) ? ONE_U : uf[FB:0];
        end
    end

    // ---------------- corner dot products ----------------
    logic signed [PW-1:0] n5_prod [8][3];
    gn3_pkg::t_dot        n6_d [8];

    always_comb begin
        logic signed [GW-1:0] g;
        logic signed [GW:0]   o;
        logic signed [SW-1:0] s;
        for (int i = 0; i < 8; i++) begin
            for (int a = 0; a < 3; a++) begin
                g = w_g[i][a*GW +: GW];
                // far corner offset t - ONE is t with a set sign bit
                o = $signed({((i >> a) & 1) != 0, r4_t[a]});
                n5_prod[i][a] = g * o;
            end
            s = SW'(r5_prod[i][0]) + SW'(r5_prod[i][1]) + SW'(r5_prod[i][2]);
            n6_d[i] = s[GFB +: DW];
        end
    end

    // ---------------- lerps ----------------
    logic signed [LPW-1:0] n7_p  [4];
    gn3_pkg::t_dot         n8_l  [4];
    logic signed [LPW-1:0] n9_p  [2];
    gn3_pkg::t_dot         n10_l [2];
    logic signed [LPW-1:0] n11_p;
    logic signed [LSW-1:0] fin;
    logic [gn3_pkg::OUT_W-1:0] n_out_data;

    always_comb begin
        logic signed [LDW-1:0] df;
        logic signed [LSW-1:0] sm;
        for (int k = 0; k < 4; k++) begin
            df = LDW'(r6_d[2*k+1]) - LDW'(r6_d[2*k]);
            n7_p[k] = df * $signed({1'b0, r6_u[0]});
            sm = LSW'(r7_a[k]) + $signed(r7_p[k][LPW-1:FB]);
            n8_l[k] = sm[DW-1:0];
        end
        for (int k = 0; k < 2; k++) begin
            df = LDW'(r8_l[2*k+1]) - LDW'(r8_l[2*k]);
            n9_p[k] = df * $signed({1'b0, r8_u[1]});
            sm = LSW'(r9_a[k]) + $signed(r9_p[k][LPW-1:FB]);
            n10_l[k] = sm[DW-1:0];
        end
        df = LDW'(r10_l[1]) - LDW'(r10_l[0]);
        n11_p = df * $signed({1'b0, r10_u2});
        fin = LSW'(r11_a) + $signed(r11_p[LPW-1:FB]) + HALF;
        if (fin > SAT_MAX) begin
            n_out_data = SAT_MAX[gn3_pkg::OUT_W-1:0];
        end else if (fin < SAT_MIN) begin
            n_out_data = SAT_MIN[gn3_pkg::OUT_W-1:0];
        end else begin
            n_out_data = fin[gn3_pkg::OUT_W-1:0];
        end
    end

    // ---------------- control: valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid    <= 1'b0;
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r6_valid    <= 1'b0;
            r7_valid    <= 1'b0;
            r8_valid    <= 1'b0;
            r9_valid    <= 1'b0;
            r10_valid   <= 1'b0;
            r11_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r0_valid    <= s_axis_tvalid && in_known;
            r1_valid    <= r0_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            // only evaluations continue past the table stages
            r4_valid    <= r3_valid && (r3_cmd == gn3_pkg::CMD_EVAL);
            r5_valid    <= r4_valid;
            r6_valid    <= r5_valid;
            r7_valid    <= r6_valid;
            r8_valid    <= r7_valid;
            r9_valid    <= r8_valid;
            r10_valid   <= r9_valid;
            r11_valid   <= r10_valid;
            r_out_valid <= r11_valid;
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_cmd  <= in_cmd;
            r0_idx  <= in_idx;
            r0_pval <= in_pval;
            r0_grad <= in_grad;
            for (int a = 0; a < 3; a++) begin
                r0_t[a]  <= in_coord[a][FB-1:0];
                r0_lo[a] <= in_coord[a][FB +: LB];
            end

            r1_cmd  <= r0_cmd;
            r1_idx  <= r0_idx;
            r1_pval <= r0_pval;
            r1_grad <= r0_grad;
            r2_cmd  <= r1_cmd;
            r2_idx  <= r1_idx;
            r2_grad <= r1_grad;
            r3_cmd  <= r2_cmd;
            r3_idx  <= r2_idx;
            r3_grad <= r2_grad;
            for (int a = 0; a < 3; a++) begin
                r1_t[a]  <= r0_t[a];
                r2_t[a]  <= r1_t[a];
                r3_t[a]  <= r2_t[a];
                r4_t[a]  <= r3_t[a];
                r1_lo[a] <= r0_lo[a];
                r2_lo[a] <= r1_lo[a];
                r1_k[a]  <= n1_k[a];
                r1_t2[a] <= n1_t2[a];
                r2_t3[a] <= n2_t3[a];
                r2_m[a]  <= n2_m[a];
                r3_t3[a] <= r2_t3[a];
                r3_rr[a] <= n3_rr[a];
                r4_u[a]  <= n4_u[a];
                r5_u[a]  <= r4_u[a];
                r6_u[a]  <= r5_u[a];
                r7_u[a]  <= r6_u[a];
                r8_u[a]  <= r7_u[a];
                r9_u[a]  <= r8_u[a];
            end
            r5_prod <= n5_prod;
            r6_d    <= n6_d;
            for (int k = 0; k < 4; k++) begin
                r7_a[k] <= r6_d[2*k];
            end
            r7_p    <= n7_p;
            r8_l    <= n8_l;
            for (int k = 0; k < 2; k++) begin
                r9_a[k] <= r8_l[2*k];
            end
            r9_p       <= n9_p;
            r10_l      <= n10_l;
            r10_u2     <= r9_u[2];
            r11_a      <= r10_l[0];
            r11_p      <= n11_p;
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = MW'(r_out_data);

    // ---------------- checks ----------------
    logic fade_in_range;
    logic eval_beat;

    assign fade_in_range = (r4_u[0] <= ONE_U) && (r4_u[1] <= ONE_U) && (r4_u[2] <= ONE_U);
    assign eval_beat     = s_axis_tvalid && s_axis_tready && (in_cmd == gn3_pkg::CMD_EVAL);

    `GN3_ASSERT_IMPL(a_fade_clamped, r4_valid, fade_in_range)
    `GN3_ASSERT_NEXT(a_load_no_result, en && r3_valid && (r3_cmd != gn3_pkg::CMD_EVAL), !r4_valid)
    `GN3_ASSERT_NEXT(a_stall_holds_dots, !en && r6_valid, r6_valid && $stable(r6_d[0]) && $stable(r6_d[7]))
    `GN3_ASSERT_NEXT(a_eval_enters, eval_beat, r0_valid && (r0_cmd == gn3_pkg::CMD_EVAL))

endmodule

[sv/gn3_ram.sv]
// Simple dual-read RAM: one write port, two registered read ports.
// Standalone; used for the permutation and gradient tables.
`timescale 1ns / 1ps

module gn3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while the pipeline stalls
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[tb/tb.sv]
// Self-checking testbench for gradient_noise_3d_eval: loads both lookup tables,
// then streams directed evaluations and a random mix of all commands, with stalls on both sides.
// Depends on gn3_pkg and the gradient_noise_3d_eval RTL.
`timescale 1ns / 1ps

module tb;

    localparam int FRAC_BITS      = gn3_pkg::FRAC_BITS;
    localparam int GRAD_FRAC_BITS = gn3_pkg::GRAD_FRAC_BITS;
    localparam int LATTICE_SIZE   = gn3_pkg::LATTICE_SIZE;
    localparam int PERM_DEPTH     = gn3_pkg::PERM_DEPTH;
    localparam int COORD_W        = gn3_pkg::COORD_W;
    localparam int OUT_W          = gn3_pkg::OUT_W;
    localparam int S_TDATA_W      = gn3_pkg::S_TDATA_W;
    localparam int S_TUSER_W      = gn3_pkg::S_TUSER_W;
    localparam int M_TDATA_W      = gn3_pkg::M_TDATA_W;
    localparam logic [1:0] CMD_LOAD_PERM = gn3_pkg::CMD_LOAD_PERM;
    localparam logic [1:0] CMD_LOAD_GRAD = gn3_pkg::CMD_LOAD_GRAD;
    localparam logic [1:0] CMD_EVAL      = gn3_pkg::CMD_EVAL;

    localparam logic [1:0] CMD_UNUSED = 2'd3;  // no meaning, block ignores it
    localparam int STALL_LIMIT = 5000;         // cycles with no beat on either side
    localparam int HOLD_CYCLES = 300;          // long receiver hold-off
    localparam int RANDOM_BEATS = 420;         // random mix after the table fill
    localparam int ONE_Q = 1 << FRAC_BITS;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    gradient_noise_3d_eval u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // shadow copies of the block's tables
    logic [7:0]      perm_shadow [PERM_DEPTH];
    int              grad_shadow [LATTICE_SIZE][3];
    logic [OUT_W-1:0] noise_due [$];

    int  fail_cnt;
    int  noise_seen;
    int  eval_sent;
    int  load_sent;
    int  burst_left;
    bit  gaps_on;
    bit  hold_req;
    bit  hold_done;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    function automatic longint fade_curve(longint t);
        longint t2, t3, r, u;
        t2 = (t * t) >>> FRAC_BITS;
        t3 = (t2 * t) >>> FRAC_BITS;
        r  = 10 * ONE_Q - ((t * (15 * ONE_Q - 6 * t)) >>> FRAC_BITS);
        u  = (t3 * r) >>> FRAC_BITS;
        return (u > ONE_Q) ? ONE_Q : u;
    endfunction

    function automatic longint mix_lerp(longint a, longint b, longint u);
        return a + (((b - a) * u) >>> FRAC_BITS);
    endfunction

    // three chained lookups, final word picks a gradient
    function automatic int corner_grad(int x, int y, int z);
        int h;
        h = perm_shadow[x % PERM_DEPTH];
        h = perm_shadow[(h + y) % PERM_DEPTH];
        h = perm_shadow[(h + z) % PERM_DEPTH];
        return h % LATTICE_SIZE;
    endfunction

    function automatic logic [OUT_W-1:0] noise_at(logic [COORD_W-1:0] cx,
                                                  logic [COORD_W-1:0] cy,
                                                  logic [COORD_W-1:0] cz);
        longint ofs [3][2];
        longint fu [3];
        longint d [8];
        longint s, r;
        int lo [3];
        int hi [3];
        logic [COORD_W-1:0] c;
        int g, bx, by, bz;
        for (int i = 0; i < 3; i++) begin
            c = (i == 0) ? cx : (i == 1) ? cy : cz;
            lo[i] = (c >> FRAC_BITS) % LATTICE_SIZE;
            hi[i] = (lo[i] + 1) % LATTICE_SIZE;
            ofs[i][0] = c[FRAC_BITS-1:0];
            ofs[i][1] = ofs[i][0] - ONE_Q;
            fu[i] = fade_curve(ofs[i][0]);
        end
        for (int k = 0; k < 8; k++) begin
            bx = k & 1;
            by = (k >> 1) & 1;
            bz = (k >> 2) & 1;
            g = corner_grad(bx ? hi[0] : lo[0], by ? hi[1] : lo[1], bz ? hi[2] : lo[2]);
            s = longint'(grad_shadow[g][0]) * ofs[0][bx]
              + longint'(grad_shadow[g][1]) * ofs[1][by]
              + longint'(grad_shadow[g][2]) * ofs[2][bz];
            d[k] = s >>> GRAD_FRAC_BITS;
        end
        r = mix_lerp(mix_lerp(mix_lerp(d[0], d[1], fu[0]), mix_lerp(d[2], d[3], fu[0]), fu[1]),
                     mix_lerp(mix_lerp(d[4], d[5], fu[0]), mix_lerp(d[6], d[7], fu[0]), fu[1]),
                     fu[2]);
        r = r + ONE_Q / 2;  // FRAC_BITS equals the output fraction, no rescale
        if (r > 131071)
            r = 131071;
        if (r < -131072)
            r = -131072;
        return r[OUT_W-1:0];
    endfunction

    // ---------------- sender ----------------

    // one beat; the shadow tables and the expected queue update on acceptance
    task automatic send_beat(logic [1:0] cmd, logic [8:0] idx, logic [7:0] pv,
                             logic [15:0] gx, logic [15:0] gy, logic [15:0] gz,
                             logic [23:0] cx, logic [23:0] cy, logic [23:0] cz);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'b0, cz, cy, cx, gz, gy, gx, pv, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        case (cmd)
            CMD_LOAD_PERM: begin
                perm_shadow[idx % PERM_DEPTH] = pv;
                load_sent++;
            end
            CMD_LOAD_GRAD: begin
                grad_shadow[idx % LATTICE_SIZE][0] = $signed(gx);
                grad_shadow[idx % LATTICE_SIZE][1] = $signed(gy);
                grad_shadow[idx % LATTICE_SIZE][2] = $signed(gz);
                load_sent++;
            end
            CMD_EVAL: begin
                noise_due.push_back(noise_at(cx, cy, cz));
                eval_sent++;
            end
            default: ;  // unused command, nothing changes
        endcase
        if (gaps_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    task automatic send_eval(logic [23:0] cx, logic [23:0] cy, logic [23:0] cz);
        send_beat(CMD_EVAL, 9'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), cx, cy, cz);
    endtask

    function automatic logic [15:0] rand_grad();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    task automatic send_grad(logic [8:0] idx, logic [15:0] gx, logic [15:0] gy,
                             logic [15:0] gz);
        send_beat(CMD_LOAD_GRAD, idx, 8'($urandom), gx, gy, gz, 24'($urandom),
                  24'($urandom), 24'($urandom));
    endtask

    task automatic send_perm(logic [8:0] idx, logic [7:0] pv);
        send_beat(CMD_LOAD_PERM, idx, pv, 16'($urandom), 16'($urandom), 16'($urandom),
                  24'($urandom), 24'($urandom), 24'($urandom));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (noise_due.size() != 0) @(posedge i_clk);
    endtask

    // ---------------- receiver ----------------

    // segments of always-ready, random and periodic stalls; long hold on request
    initial begin : rx_stall
        int cyc;
        cyc = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req  = 1'b0;
                hold_done = 1'b1;
            end else begin
                case ((cyc / 64) % 3)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= (cyc % 5 != 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            noise_seen++;
            if (noise_due.size() == 0) begin
                $error("noise_value: beat with nothing expected, actual %0d",
                       $signed(m_axis_tdata[OUT_W-1:0]));
                fail_cnt++;
            end else begin
                want = noise_due.pop_front();
                if (m_axis_tdata[OUT_W-1:0] !== want) begin
                    $error("noise_value: expected %0d, actual %0d",
                           $signed(want), $signed(m_axis_tdata[OUT_W-1:0]));
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        int idle;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle = 0;
        else
            idle++;
        if (idle >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------- tests ----------------

    // every entry written once, so no evaluation ever reads an unwritten word
    task automatic test_table_load();
        for (int i = 0; i < PERM_DEPTH; i++)
            send_perm(9'(i), (i < 2) ? 8'(i * 255) : 8'($urandom));
        send_grad(9'd0, 16'sd16384, 16'sd16384, 16'sd16384);
        send_grad(9'd1, -16'sd16384, -16'sd16384, -16'sd16384);
        send_grad(9'd2, 16'sd16384, -16'sd16384, 16'sd0);
        for (int i = 3; i < LATTICE_SIZE; i++)
            send_grad(9'(i), rand_grad(), rand_grad(), rand_grad());
    endtask

    task automatic test_directed_eval();
        send_eval(24'h000000, 24'h000000, 24'h000000);
        send_eval(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);    // top cell wraps to zero
        send_eval(24'h00FFFF, 24'h00FFFF, 24'h00FFFF);
        send_eval(24'h008000, 24'h008000, 24'h008000);    // cell center
        send_eval(24'hFF0000, 24'h000001, 24'hFF8000);
        send_eval(24'h7F4000, 24'h80C000, 24'h010000);
        // unused command between evaluations must change nothing
        send_beat(CMD_UNUSED, 9'h1FF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_eval(24'h123456, 24'hABCDEF, 24'h00FFFF);
        // upper half of the doubled permutation table and the 9th index bit
        send_perm(9'h1FF, 8'hFF);
        send_perm(9'h100, 8'h00);
        send_grad(9'h1FF, -16'sd16384, 16'sd16384, -16'sd1);   // lands on entry 255
        send_eval(24'hFF8000, 24'hFF8000, 24'hFF8000);
        send_eval(24'h000000, 24'hFFFFFF, 24'h008000);
    endtask

    // sender stops until every noise value is back
    task automatic test_pause_drain();
        for (int i = 0; i < 8; i++)
            send_eval(24'($urandom), 24'($urandom), 24'($urandom));
        wait_drained();
    endtask

    // long receiver hold while the sender keeps offering beats back to back
    task automatic test_backpressure();
        gaps_on   = 1'b0;
        hold_done = 1'b0;
        hold_req  = 1'b1;
        for (int i = 0; i < 48; i++)
            send_eval(24'($urandom), 24'($urandom), 24'($urandom));
        s_axis_tvalid <= 1'b0;
        while (!hold_done) @(posedge i_clk);
        gaps_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_random_mix();
        int pick;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            pick = $urandom_range(0, 99);
            if (n % 300 < 40)
                gaps_on = 1'b0;  // stretch with no sender gaps
            else
                gaps_on = 1'b1;
            if (pick < 72)
                send_eval(24'($urandom), 24'($urandom), 24'($urandom));
            else if (pick < 84)
                send_perm(9'($urandom), 8'($urandom));
            else if (pick < 96)
                send_grad(9'($urandom), rand_grad(), rand_grad(), rand_grad());
            else
                send_beat(CMD_UNUSED, 9'($urandom), 8'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom));
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        fail_cnt   = 0;
        noise_seen = 0;
        eval_sent  = 0;
        load_sent  = 0;
        burst_left = 8;
        gaps_on    = 1'b1;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= CMD_LOAD_PERM;
        s_axis_tdata  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_load();
        test_directed_eval();
        test_pause_drain();
        test_backpressure();
        test_random_mix();

        wait_drained();
        repeat (30) @(posedge i_clk);  // allow for stray beats still in the pipeline

        $display("Covered %0d table loads and %0d evaluations, %0d noise values checked,",
                 load_sent, eval_sent, noise_seen);
        $display("with sender bursts, receiver stalls and a %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (fail_cnt == 0 && noise_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[gradient_noise_3d_eval.f]
+incdir+sv
sv/gn3_pkg.sv
sv/gn3_ram.sv
sv/gradient_noise_3d_eval.sv
tb/tb.sv
